@@ hdl/kts_pkg.sv @@
// Shared types, constants and helpers for the keyframe track sampler.
// No dependencies; imported by the divider, the top level and the testbench.
package kts_pkg;

    localparam int MAX_KEYS       = 256;
    localparam int MAX_COMPONENTS = 4;
    localparam int VALUE_DEPTH    = MAX_KEYS * MAX_COMPONENTS * 3;
    localparam int KEY_AW         = $clog2(MAX_KEYS);
    localparam int VAL_AW         = $clog2(VALUE_DEPTH);
    localparam int DIV_W          = 48;   // dividend / quotient width
    localparam int DIV_CW         = $clog2(DIV_W);

    // request opcodes
    typedef enum logic [1:0] {
        OP_KEY_TIME = 2'd0,
        OP_VALUE    = 2'd1,
        OP_SAMPLE   = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    // interpolation modes
    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_CUBIC  = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_COMPONENTS = 2'd0;
    localparam logic [1:0] CFG_KEY_COUNT  = 2'd1;
    localparam logic [1:0] CFG_INTERP     = 2'd2;
    localparam logic [1:0] CFG_LOOP_LEN   = 2'd3;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef logic signed [32:0] t_mop;   // multiplier operand
    typedef logic signed [65:0] t_prod;  // multiplier product

    typedef enum logic [4:0] {
        S_IDLE, S_MOD, S_MODW, S_RDF, S_RDL, S_CLMP, S_CUR, S_WRD, S_WCMP,
        S_PRV, S_NXT, S_TQ, S_DIVS, S_DIVW, S_T2, S_T2R, S_T3, S_T3R, S_H,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_MUL, S_RND, S_EMIT
    } t_state;

    function automatic t_mop mop_u32(input logic [31:0] x);
        return {1'b0, x};
    endfunction

    function automatic t_mop mop_s32(input logic [31:0] x);
        return {x[31], x};
    endfunction

    function automatic t_mop mop_u17(input logic [16:0] x);
        return {16'd0, x};
    endfunction

    function automatic t_mop mop_s20(input logic [19:0] x);
        return {{13{x[19]}}, x};
    endfunction

    // Q32 -> Q16, round to nearest (ties up), saturate to signed 32 bits
    function automatic logic [31:0] sat_round(input t_prod x);
        t_prod y;
        y = (x + 66'sd32768) >>> 16;
        if (y > 66'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (y < -66'sd2147483648)
            return 32'h8000_0000;
        else
            return y[31:0];
    endfunction

endpackage

@@ hdl/keyframe_track_sampler.sv @@
// Top level of the keyframe track sampler: sequencer, key/value memories,
// shared multiplier. Depends on kts_pkg, kts_ram and kts_div.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries requests: op 0 writes a
//   key time, op 1 writes a value word, op 2 samples at a time, op 3 is
//   dropped. A sample gives component_count results on the output channel
//   (o_out_valid / i_out_stall), o_last on the final.
//   Config (i_cfg_valid / o_cfg_ready) is always ready; write it only idle.
// Steps of one sample
//   After acceptance: the loop wrap on the 48-step divider (skipped when the
//   loop length is zero), the clamp, a walk over the keys from the cursor,
//   the interval fetch, the normalizing divide (skipped when the interval is
//   empty or the time is not past its first key) and the Hermite basis, then
//   per component the value reads, multiplies and rounding (none in step).
// Reset
//   Synchronous active-low; config returns to 3 components, 2 keys, linear,
//   loop 1.0; cursor and previous time clear. Memories are not cleared.
// Backpressure
//   The output register holds a result while i_out_stall is high; the
//   sequencer waits before each further component and the next request is
//   taken once the last result has been loaded into the output register.
module keyframe_track_sampler import kts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [11:0] i_index,
    input  logic [31:0] i_word,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_component,
    output logic signed [31:0] o_sample_value,
    output logic        o_last,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // ---------------- config ----------------
    logic [2:0]  r_comp_cnt;
    logic [8:0]  r_key_cnt;
    logic [1:0]  r_mode;
    logic [31:0] r_loop_len;

    logic [2:0] cc;
    logic [8:0] kc;
    logic       is_step;
    logic       is_cubic;

    assign cc = (r_comp_cnt == 3'd0) ? 3'd1 :
                (r_comp_cnt > 3'(MAX_COMPONENTS)) ? 3'(MAX_COMPONENTS) : r_comp_cnt;
    assign kc = (r_key_cnt < 9'd2) ? 9'd2 :
                (r_key_cnt > 9'(MAX_KEYS)) ? 9'(MAX_KEYS) : r_key_cnt;
    assign is_step  = (r_mode == MODE_STEP);
    assign is_cubic = (r_mode == MODE_CUBIC);

    // ---------------- state ----------------
    t_state r_state, n_state;
    logic   r_out_valid;

    logic in_acc;
    logic out_free;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    logic [31:0] r_t;
    logic [31:0] r_first;
    logic [31:0] r_prev;
    logic [7:0]  r_cursor;
    logic [8:0]  r_i;
    logic [7:0]  r_nk;
    logic [7:0]  r_pk;
    logic [31:0] r_tp;
    logic [31:0] r_delta;
    logic [16:0] r_tn;
    logic [16:0] r_t2;
    logic [16:0] r_t3;
    logic signed [19:0] r_h00, r_h10, r_h01, r_h11;
    logic [11:0] r_pbase, r_nbase;
    logic [1:0]  r_c;
    logic [31:0] r_va, r_vb, r_vc, r_vd;
    logic [31:0] r_a, r_b;
    logic signed [55:0] r_acc;
    logic [2:0]  r_k;
    t_prod       r_prod;
    logic [31:0] r_res;
    logic [1:0]  r_out_comp;
    logic [31:0] r_out_value;
    logic        r_out_last;

    // ---------------- memories ----------------
    logic              tm_we, vl_we;
    logic [KEY_AW-1:0] tm_raddr;
    logic [VAL_AW-1:0] vl_raddr;
    logic [31:0]       tm_rdata, vl_rdata;

    assign tm_we = in_acc && (i_op == OP_KEY_TIME) && (i_index < 12'(MAX_KEYS));
    assign vl_we = in_acc && (i_op == OP_VALUE) && (i_index < 12'(VALUE_DEPTH));

    kts_ram #(.DEPTH(MAX_KEYS), .DATA_W(32)) u_times (
        .i_clk   (i_clk),
        .i_we    (tm_we),
        .i_waddr (i_index[KEY_AW-1:0]),
        .i_wdata (i_word),
        .i_raddr (tm_raddr),
        .o_rdata (tm_rdata)
    );

    kts_ram #(.DEPTH(VALUE_DEPTH), .DATA_W(32)) u_values (
        .i_clk   (i_clk),
        .i_we    (vl_we),
        .i_waddr (i_index[VAL_AW-1:0]),
        .i_wdata (i_word),
        .i_raddr (vl_raddr),
        .o_rdata (vl_rdata)
    );

    // ---------------- divider ----------------
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [31:0]      div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [31:0]      div_rem;

    kts_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    logic norm_go;
    assign norm_go = (r_delta != 32'd0) && (r_t > r_tp);

    // ---------------- helpers ----------------
    logic [2:0]  mul_steps;
    logic        is_lastc;
    logic [11:0] off_c, off_cc, off_2cc;
    logic [31:0] clamp_t;
    t_prod       prod_rnd;
    logic signed [19:0] t2s, t3s, tns;

    assign mul_steps = is_cubic ? 3'd6 : 3'd2;
    assign is_lastc  = ({1'b0, r_c} == (cc - 3'd1));
    assign off_c     = 12'(r_c);
    assign off_cc    = 12'(cc) + off_c;
    assign off_2cc   = 12'(cc) + off_cc;
    assign clamp_t   = (r_t < r_first) ? r_first : (r_t > tm_rdata) ? tm_rdata : r_t;
    assign prod_rnd  = (r_prod + 66'sd32768) >>> 16;
    assign t2s       = $signed({3'b000, r_t2});
    assign t3s       = $signed({3'b000, r_t3});
    assign tns       = $signed({3'b000, r_tn});

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && i_op == OP_SAMPLE) n_state = S_MOD;
            S_MOD:   n_state = (r_loop_len != 32'd0) ? S_MODW : S_RDF;
            S_MODW:  if (div_done) n_state = S_RDF;
            S_RDF:   n_state = S_RDL;
            S_RDL:   n_state = S_CLMP;
            S_CLMP:  n_state = S_CUR;
            S_CUR:   n_state = S_WRD;
            S_WRD:   n_state = (r_i >= kc) ? S_PRV : S_WCMP;
            S_WCMP:  n_state = (r_t <= tm_rdata) ? S_PRV : S_WRD;
            S_PRV:   n_state = S_NXT;
            S_NXT:   n_state = S_TQ;
            S_TQ:    n_state = S_DIVS;
            S_DIVS:  n_state = norm_go ? S_DIVW : S_T2;
            S_DIVW:  if (div_done) n_state = S_T2;
            S_T2:    n_state = S_T2R;
            S_T2R:   n_state = S_T3;
            S_T3:    n_state = S_T3R;
            S_T3R:   n_state = S_H;
            S_H:     n_state = S_R0;
            S_R0:    n_state = S_R1;
            S_R1:    n_state = S_R2;
            S_R2:    n_state = S_R3;
            S_R3:    n_state = S_R4;
            S_R4:    n_state = is_step ? S_EMIT : S_MUL;
            S_MUL:   if (r_k == mul_steps) n_state = S_RND;
            S_RND:   n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = is_lastc ? S_IDLE : S_R0;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    t_mop mop_a, mop_b;

    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        tm_raddr     = r_i[KEY_AW-1:0];
        vl_raddr     = r_pbase + off_c;
        div_start    = 1'b0;
        div_dividend = {16'd0, r_t};
        div_divisor  = r_loop_len;
        mop_a        = '0;
        mop_b        = '0;
        unique case (r_state)
            S_MOD: div_start = (r_loop_len != 32'd0);
            S_RDF: tm_raddr = '0;
            S_RDL: tm_raddr = KEY_AW'(kc - 9'd1);
            S_PRV: tm_raddr = r_nk - 8'd1;
            S_NXT: tm_raddr = r_nk;
            S_DIVS: begin
                div_start    = norm_go;
                div_dividend = {r_t - r_tp, 16'd0};
                div_divisor  = r_delta;
            end
            S_T2: begin
                mop_a = mop_u17(r_tn);
                mop_b = mop_u17(r_tn);
            end
            S_T3: begin
                mop_a = mop_u17(r_t2);
                mop_b = mop_u17(r_tn);
            end
            // cubic: in-tan(next), out-tan(prev), value(prev), value(next)
            S_R0: vl_raddr = is_cubic ? r_nbase + off_c : r_pbase + off_c;
            S_R1: vl_raddr = is_cubic ? r_pbase + off_2cc : r_nbase + off_c;
            S_R2: vl_raddr = r_pbase + off_cc;
            S_R3: vl_raddr = r_nbase + off_cc;
            S_MUL: begin
                if (is_cubic) begin
                    case (r_k)
                        3'd0:    begin mop_a = mop_u32(r_delta); mop_b = mop_s32(r_va); end
                        3'd1:    begin mop_a = mop_u32(r_delta); mop_b = mop_s32(r_vb); end
                        3'd2:    begin mop_a = mop_s20(r_h00);   mop_b = mop_s32(r_vc); end
                        3'd3:    begin mop_a = mop_s20(r_h01);   mop_b = mop_s32(r_vd); end
                        3'd4:    begin mop_a = mop_s20(r_h11);   mop_b = mop_s32(r_a);  end
                        3'd5:    begin mop_a = mop_s20(r_h10);   mop_b = mop_s32(r_b);  end
                        default: begin mop_a = '0;               mop_b = '0;            end
                    endcase
                end else begin
                    case (r_k)
                        3'd0:    begin mop_a = mop_u17(ONE_Q16 - r_tn); mop_b = mop_s32(r_va); end
                        3'd1:    begin mop_a = mop_u17(r_tn);           mop_b = mop_s32(r_vb); end
                        default: begin mop_a = '0;                      mop_b = '0;            end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_comp_cnt  <= 3'd3;
            r_key_cnt   <= 9'd2;
            r_mode      <= MODE_LINEAR;
            r_loop_len  <= 32'd65536;
            r_cursor    <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COMPONENTS: r_comp_cnt <= i_cfg_data[2:0];
                    CFG_KEY_COUNT:  r_key_cnt  <= i_cfg_data[8:0];
                    CFG_INTERP:     r_mode     <= i_cfg_data[1:0];
                    CFG_LOOP_LEN:   r_loop_len <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_CUR) begin
                r_prev <= r_t;
            end
            if (r_state == S_PRV) begin
                r_cursor <= r_nk - 8'd1;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mop_a * mop_b;
        case (r_state)
            S_IDLE: if (in_acc) r_t <= i_word;
            S_MODW: if (div_done) r_t <= div_rem;
            S_RDL:  r_first <= tm_rdata;
            S_CLMP: r_t <= clamp_t;
            // time went backwards: restart the walk at key zero
            S_CUR:  r_i <= (r_prev > r_t) ? 9'd0 : {1'b0, r_cursor};
            S_WRD:  if (r_i >= kc) r_nk <= 8'(kc - 9'd1);
            S_WCMP: begin
                if (r_t <= tm_rdata) begin
                    r_nk <= (r_i == 9'd0) ? 8'd1 : r_i[7:0];
                end else begin
                    r_i <= r_i + 9'd1;
                end
            end
            S_PRV:  r_pk <= r_nk - 8'd1;
            S_NXT:  r_tp <= tm_rdata;
            S_TQ:   r_delta <= (tm_rdata > r_tp) ? tm_rdata - r_tp : 32'd0;
            S_DIVS: if (!norm_go) r_tn <= '0;
            S_DIVW: begin
                if (div_done) begin
                    r_tn <= (div_quo > DIV_W'(ONE_Q16)) ? ONE_Q16 : div_quo[16:0];
                end
            end
            S_T2R:  r_t2 <= prod_rnd[16:0];
            S_T3R:  r_t3 <= prod_rnd[16:0];
            S_H: begin
                r_h00   <= (t3s <<< 1) - (t2s + (t2s <<< 1)) + 20'sd65536;
                r_h10   <= t3s - (t2s <<< 1) + tns;
                r_h01   <= (t2s + (t2s <<< 1)) - (t3s <<< 1);
                r_h11   <= t3s - t2s;
                r_pbase <= is_cubic ? 12'(r_pk) * 12'(cc) * 12'd3 : 12'(r_pk) * 12'(cc);
                r_nbase <= is_cubic ? 12'(r_nk) * 12'(cc) * 12'd3 : 12'(r_nk) * 12'(cc);
                r_c     <= '0;
            end
            S_R1:   r_va <= vl_rdata;
            S_R2:   r_vb <= vl_rdata;
            S_R3:   r_vc <= vl_rdata;
            S_R4: begin
                r_vd  <= vl_rdata;
                r_acc <= '0;
                r_k   <= '0;
                r_res <= r_va;
            end
            S_MUL: begin
                r_k <= r_k + 3'd1;
                if (r_k != 3'd0) begin
                    if (is_cubic && r_k == 3'd1) begin
                        r_a <= sat_round(r_prod);
                    end else if (is_cubic && r_k == 3'd2) begin
                        r_b <= sat_round(r_prod);
                    end else begin
                        r_acc <= r_acc + r_prod[55:0];
                    end
                end
            end
            S_RND:  r_res <= sat_round({{10{r_acc[55]}}, r_acc});
            S_EMIT: begin
                if (out_free) begin
                    r_out_comp  <= r_c;
                    r_out_value <= r_res;
                    r_out_last  <= is_lastc;
                    r_c         <= r_c + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_component    = r_out_comp;
    assign o_sample_value = r_out_value;
    assign o_last         = r_out_last;
    assign o_cfg_ready    = 1'b1;

endmodule

@@ hdl/kts_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kts_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/kts_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on kts_pkg for widths.
module kts_div import kts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [31:0]      i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient,
    output logic [31:0]      o_remainder
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [31:0]       r_rem;
    logic [31:0]       r_div;

    logic [32:0] rem_sh;
    logic        fits;
    logic [32:0] rem_nx;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};
    assign rem_nx = fits ? rem_sh - {1'b0, r_div} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= rem_nx[31:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_track_sampler: loads key tables, sweeps
// configs and samples, checks each result against an in-bench predictor.
// Depends on kts_pkg and the keyframe_track_sampler RTL.
module tb_top;
    import kts_pkg::*;

    // spacing of key times: key k sits at k * KEY_STEP when laid out in order
    localparam logic [31:0] KEY_STEP = 32'h0000_4000;
    // table entries loaded up front; every phase stays inside them
    localparam int LOAD_KEYS   = 32;
    localparam int LOAD_VALUES = 96;
    // mode code with no meaning of its own, handled as linear
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = OP_NOP;
    logic [11:0] i_index = '0;
    logic [31:0] i_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_component;
    logic signed [31:0] o_sample_value;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_COMPONENTS;
    logic [31:0] i_cfg_data = '0;

    keyframe_track_sampler dut (.*);

    always #1 i_clk = ~i_clk;

    // one interpolated component as seen on the result port
    typedef struct packed {
        logic [1:0]  component;
        logic [31:0] sample_value;
        logic        last;
    } t_component_out;

    t_component_out pending_q[$];
    int unsigned    errors = 0;

    // predictor copy of tables, cursor and registers
    logic [31:0] key_time_mem [MAX_KEYS];
    logic [31:0] key_value_mem [VALUE_DEPTH];
    logic [31:0] cursor_q;
    logic [31:0] last_time_q;
    logic [2:0]  comp_reg;
    logic [8:0]  keys_reg;
    logic [1:0]  mode_reg;
    logic [31:0] loop_reg;

    bit in_idle_en  = 1'b1;
    bit out_idle_en = 1'b1;
    logic [31:0] walk_time = '0;   // running sample time for forward sweeps

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Q32 -> Q16, nearest with ties up (floor of x + 0.5)
    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip_s32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint value_word(int unsigned idx);
        return longint'($signed(key_value_mem[idx]));
    endfunction

    // expected components for one sample request
    task automatic predict_sample(logic [31:0] req_time);
        int unsigned cc, kc, nk, pk, i, c;
        logic [31:0] t, tp, tq, delta;
        logic [63:0] quo;
        longint tn, t2, t3, h00, h10, h01, h11, r, v0, v1, a, b;
        int unsigned pb, nb;
        t_component_out e;
        cc = comp_reg;
        if (cc < 1) cc = 1;
        if (cc > MAX_COMPONENTS) cc = MAX_COMPONENTS;
        kc = keys_reg;
        if (kc < 2) kc = 2;
        if (kc > MAX_KEYS) kc = MAX_KEYS;

        t = (loop_reg != 0) ? req_time % loop_reg : req_time;
        if (t < key_time_mem[0]) t = key_time_mem[0];
        else if (t > key_time_mem[kc-1]) t = key_time_mem[kc-1];

        // time went backwards: restart the key walk
        if (last_time_q > t) cursor_q = 0;
        last_time_q = t;

        nk = kc - 1;
        for (i = cursor_q; i < kc; i++) begin
            if (t <= key_time_mem[i]) begin
                nk = (i < 1) ? 1 : i;
                break;
            end
        end
        pk = nk - 1;
        cursor_q = pk;

        tp = key_time_mem[pk];
        tq = key_time_mem[nk];
        delta = (tq > tp) ? tq - tp : 32'd0;
        tn = 0;
        if (delta != 0 && t > tp) begin
            quo = {32'd0, t - tp} << 16;
            quo = quo / {32'd0, delta};
            tn = (quo > 64'd65536) ? 64'sd65536 : longint'(quo);
        end

        t2 = round_q16(tn * tn);
        t3 = round_q16(t2 * tn);
        h00 = 2*t3 - 3*t2 + 65536;
        h10 = t3 - 2*t2 + tn;
        h01 = -2*t3 + 3*t2;
        h11 = t3 - t2;

        for (c = 0; c < cc; c++) begin
            if (mode_reg == MODE_STEP) begin
                r = value_word(pk*cc + c);
            end else if (mode_reg == MODE_CUBIC) begin
                // per key: in-tangents, values, out-tangents
                pb = pk*cc*3;
                nb = nk*cc*3;
                v0 = value_word(pb + cc + c);
                b  = clip_s32(round_q16(longint'(delta) * value_word(pb + 2*cc + c)));
                a  = clip_s32(round_q16(longint'(delta) * value_word(nb + c)));
                v1 = value_word(nb + cc + c);
                r  = clip_s32(round_q16(h00*v0 + h10*b + h01*v1 + h11*a));
            end else begin
                v0 = value_word(pk*cc + c);
                v1 = value_word(nk*cc + c);
                r  = clip_s32(round_q16(v0*(65536 - tn) + v1*tn));
            end
            e.component    = c[1:0];
            e.sample_value = r[31:0];
            e.last         = (c == cc - 1);
            pending_q = {pending_q, e};
        end
    endtask

    // send one request; returns once accepted, valid left high
    task automatic send_req(t_op op, logic [11:0] idx, logic [31:0] w);
        int unsigned gap;
        @(negedge i_clk);
        gap = in_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op = op;
        i_index = idx;
        i_word = w;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        case (op)
            OP_KEY_TIME: if (idx < MAX_KEYS) key_time_mem[idx] = w;
            OP_VALUE:    if (idx < VALUE_DEPTH) key_value_mem[idx] = w;
            OP_SAMPLE:   predict_sample(w);
            default: ;
        endcase
    endtask

    // wait for every expected result, then let trailing writes settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COMPONENTS: comp_reg = data[2:0];
            CFG_KEY_COUNT:  keys_reg = data[8:0];
            CFG_INTERP:     mode_reg = data[1:0];
            default:        loop_reg = data;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [31:0] cc, logic [31:0] kc, logic [31:0] md,
                              logic [31:0] loop_len);
        drain();
        cfg_write(CFG_COMPONENTS, cc);
        cfg_write(CFG_KEY_COUNT, kc);
        cfg_write(CFG_INTERP, md);
        cfg_write(CFG_LOOP_LEN, loop_len);
        walk_time = '0;
    endtask

    // random value word, extremes now and then so saturation is reached
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_FFFF);
            default: return $urandom();
        endcase
    endfunction

    // fill the table entries that the phases below can reach
    task automatic test_load_tables();
        int k;
        for (k = 0; k < LOAD_KEYS; k++)
            send_req(OP_KEY_TIME, k[11:0], k * KEY_STEP);
        for (k = 0; k < LOAD_VALUES; k++)
            send_req(OP_VALUE, k[11:0], pick_value());
    endtask

    // reset config: 3 components, 2 keys, linear, loop 1.0
    task automatic test_directed();
        send_req(OP_SAMPLE, 12'd0, 32'd0);
        send_req(OP_SAMPLE, 12'd0, 32'h0000_2000);
        send_req(OP_SAMPLE, 12'd0, KEY_STEP);
        // wraps to just under 1.0, clamps to the last key
        send_req(OP_SAMPLE, 12'd0, 32'hFFFF_FFFF);
        // wraps back: time went backwards
        send_req(OP_SAMPLE, 12'hFFF, 32'h0001_1000);
        send_req(OP_NOP, 12'hABC, 32'hDEAD_BEEF);
        send_req(OP_KEY_TIME, 12'hFFF, 32'h1234_5678);
        send_req(OP_VALUE, 12'hFFF, 32'h1234_5678);
        send_req(OP_VALUE, 12'hC00, 32'h5555_AAAA);
        // value extremes across the interval
        send_req(OP_VALUE, 12'd0, 32'h7FFF_FFFF);
        send_req(OP_VALUE, 12'd3, 32'h8000_0000);
        send_req(OP_VALUE, 12'd1, 32'h8000_0000);
        send_req(OP_VALUE, 12'd4, 32'h7FFF_FFFF);
        send_req(OP_SAMPLE, 12'd0, 32'h0000_3000);
        // empty interval: both keys at zero
        send_req(OP_KEY_TIME, 12'd1, 32'd0);
        send_req(OP_SAMPLE, 12'd0, 32'h0000_0800);
        // first key later than the last
        send_req(OP_KEY_TIME, 12'd0, 32'h0000_8000);
        send_req(OP_SAMPLE, 12'd0, 32'h0000_0100);
        send_req(OP_SAMPLE, 12'd0, 32'h0000_9000);
        send_req(OP_KEY_TIME, 12'd0, 32'd0);
        send_req(OP_KEY_TIME, 12'd1, KEY_STEP);
        send_req(OP_SAMPLE, 12'd0, 32'h0000_1111);
    endtask

    // mostly forward sweeps with random content; the rest noise
    task automatic test_random_phase(int n);
        int j, kc;
        int unsigned r, k;
        kc = keys_reg;
        if (kc < 2) kc = 2;
        if (kc > MAX_KEYS) kc = MAX_KEYS;
        for (j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                walk_time = walk_time + $urandom_range(0, 2 * KEY_STEP);
                send_req(OP_SAMPLE, 12'($urandom()), walk_time);
            end else if (r < 65) begin
                walk_time = $urandom_range(0, kc * KEY_STEP);
                send_req(OP_SAMPLE, 12'($urandom()), walk_time);
            end else if (r < 72) begin
                send_req(OP_SAMPLE, 12'($urandom()), $urandom());
            end else if (r < 80) begin
                // keeps keys ordered: jitter stays inside the slot
                k = $urandom_range(0, kc - 1);
                send_req(OP_KEY_TIME, k[11:0], k * KEY_STEP + $urandom_range(0, KEY_STEP - 1));
            end else if (r < 83) begin
                // index past the time table: dropped
                send_req(OP_KEY_TIME, 12'($urandom_range(MAX_KEYS, 4095)), $urandom());
            end else if (r < 97) begin
                send_req(OP_VALUE, 12'($urandom_range(0, 4095)), pick_value());
            end else begin
                send_req(OP_NOP, 12'($urandom()), $urandom());
            end
        end
    endtask

    // result side backpressure
    int unsigned stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = out_idle_en ? pick_gap() : 0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_component_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result comp=%0d value=%h last=%b",
                         $time, o_component, o_sample_value, o_last);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_component !== e.component) begin
                    $display("%0t: component exp %0d got %0d", $time,
                             e.component, o_component);
                    errors++;
                end
                if (o_sample_value !== e.sample_value) begin
                    $display("%0t: sample_value exp %h got %h", $time,
                             e.sample_value, o_sample_value);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last exp %b got %b", $time, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        cursor_q = '0;
        last_time_q = '0;
        comp_reg = 3'd3;
        keys_reg = 9'd2;
        mode_reg = MODE_LINEAR;
        loop_reg = 32'd65536;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        in_idle_en = 1'b0;
        test_load_tables();
        in_idle_en = 1'b1;
        test_directed();

        set_config(1, 32, MODE_STEP, 0);
        test_random_phase(38);
        set_config(4, 8, MODE_CUBIC, 32'hFFFF_FFFF);
        test_random_phase(38);
        // no idling on either side for one phase
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        set_config(4, 6, MODE_CUBIC, 6 * KEY_STEP);
        test_random_phase(38);
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        set_config(2, 5, MODE_LINEAR, 3 * KEY_STEP);
        test_random_phase(38);
        // out-of-range counts, unknown mode, shortest loop
        set_config(0, 0, MODE_SPARE, 1);
        test_random_phase(32);
        set_config(7, 6, MODE_CUBIC, 32'h0012_3456);
        test_random_phase(38);
        set_config(2, 32, MODE_STEP, 32'h0008_0000);
        test_random_phase(38);

        drain();
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

@@ keyframe_track_sampler.f @@
hdl/kts_pkg.sv
hdl/kts_ram.sv
hdl/kts_div.sv
hdl/keyframe_track_sampler.sv
sim/tb_top.sv
